// ===== sv/ulst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ulst_pkg
// Shared types and constants for the unordered array list core.
// ----------------------------------------------------------------------------
package ulst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int DATA_W       = 32;
    localparam int FIDX_W       = 4;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_DUMP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SCAN   = 3'd1,
        S_MOVE   = 3'd2,
        S_COMMIT = 3'd3,
        S_DUMP   = 3'd4
    } t_state;

endpackage : ulst_pkg
`default_nettype wire

// ===== sv/ulst_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ulst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ulst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : ulst_ram
`default_nettype wire

// ===== sv/unordered_array_list_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unordered_array_list_core
// Bounded unordered list of signed 32-bit values with swap-remove.
//
// Usage: present a request on i_req_type / i_item_value with start high; it
// is taken at a clock edge where busy is low. Insert appends, search returns
// the index of the first match, remove moves the last entry into the slot of
// the first match, dump emits the entries in index order (at most 16).
// Every result is shown on the o_ ports for one cycle with o_strobe high;
// o_last marks the final result of a request. The receiver cannot stall.
// Each result appears the cycle after the deciding cycle. Insert and
// any request on an empty list leave busy low. Search, remove and dump scan
// the entries in index order, since the entry RAM delivers one entry per
// cycle through its single read port; remove then moves the tail entry.
// Reset clears the count; entry contents need no clearing.
// ----------------------------------------------------------------------------
module unordered_array_list_core #(
    parameter int CAPACITY = ulst_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic [ulst_pkg::DATA_W-1:0] i_item_value,
    output logic                             o_strobe,
    output logic [1:0]                       o_status,
    output logic [ulst_pkg::FIDX_W-1:0]      o_found_index,
    output logic [ulst_pkg::DATA_W-1:0]      o_entry_value,
    output logic                             o_last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = ulst_pkg::DATA_W;
    localparam int FW    = ulst_pkg::FIDX_W;

    ulst_pkg::t_state  r_state, n_state;
    ulst_pkg::t_req    w_req;
    ulst_pkg::t_status r_status, n_status;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [DW-1:0]    r_value, n_value;
    logic             r_value_is_remove, n_value_is_remove;
    logic             r_strobe, n_strobe;
    logic [FW-1:0]    r_found, n_found;
    logic [DW-1:0]    r_entry, n_entry;
    logic             r_last, n_last;

    logic             w_accept;
    logic             w_hit;
    logic             w_scan_end;
    logic             w_dump_end;
    logic             w_full;
    logic             w_empty;
    logic [CNT_W-1:0] w_last_idx;
    logic [CNT_W-1:0] w_dump_n;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [DW-1:0]    w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [DW-1:0]    w_rdata;

    ulst_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign busy       = (r_state != ulst_pkg::S_IDLE);
    assign w_accept   = start && !busy;
    assign w_req      = ulst_pkg::t_req'(i_req_type);
    assign w_full     = (int'(r_count) >= CAPACITY);
    assign w_empty    = (r_count == '0);
    assign w_last_idx = r_count - 1'b1;
    assign w_dump_n   = (int'(r_count) > ulst_pkg::MAX_RESULTS)
                        ? CNT_W'(ulst_pkg::MAX_RESULTS) : r_count;
    assign w_hit      = r_pend && (w_rdata == r_value);
    assign w_scan_end = r_pend && (r_pend_idx == w_last_idx);
    assign w_dump_end = r_pend && (r_pend_idx == w_dump_n - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ulst_pkg::S_IDLE: begin
                if (w_accept && !w_empty) begin
                    case (w_req)
                        ulst_pkg::REQ_SEARCH,
                        ulst_pkg::REQ_REMOVE: n_state = ulst_pkg::S_SCAN;
                        ulst_pkg::REQ_DUMP:   n_state = ulst_pkg::S_DUMP;
                        default:              n_state = ulst_pkg::S_IDLE;
                    endcase
                end
            end
            ulst_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_value_is_remove) ? ulst_pkg::S_MOVE
                                                  : ulst_pkg::S_IDLE;
                end else if (w_scan_end) begin
                    n_state = ulst_pkg::S_IDLE;
                end
            end
            ulst_pkg::S_MOVE:   n_state = ulst_pkg::S_COMMIT;
            ulst_pkg::S_COMMIT: n_state = ulst_pkg::S_IDLE;
            ulst_pkg::S_DUMP: begin
                if (w_dump_end) begin
                    n_state = ulst_pkg::S_IDLE;
                end
            end
            default: n_state = ulst_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM control and result registers
    always_comb begin
        n_count           = r_count;
        n_idx             = r_idx + 1'b1;
        n_pend            = 1'b0;
        n_pend_idx        = r_idx;
        n_pos             = r_pos;
        n_value           = r_value;
        n_value_is_remove = r_value_is_remove;
        n_strobe          = 1'b0;
        n_status          = ulst_pkg::ST_OK;
        n_found           = '0;
        n_entry           = '0;
        n_last            = 1'b1;
        w_we              = 1'b0;
        w_waddr           = r_count[IDX_W-1:0];
        w_wdata           = i_item_value;
        w_raddr           = r_idx[IDX_W-1:0];
        case (r_state)
            ulst_pkg::S_IDLE: begin
                n_idx             = '0;
                n_value           = i_item_value;
                n_value_is_remove = (w_req == ulst_pkg::REQ_REMOVE);
                if (w_accept) begin
                    case (w_req)
                        ulst_pkg::REQ_INSERT: begin
                            n_strobe = 1'b1;
                            if (w_full) begin
                                n_status = ulst_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        default: begin
                            // empty list answers at once; otherwise the scan starts
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_status = ulst_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            ulst_pkg::S_SCAN: begin
                n_pend = (r_idx < r_count);
                if (w_hit) begin
                    n_pos = r_pend_idx[IDX_W-1:0];
                    if (!r_value_is_remove) begin
                        n_strobe = 1'b1;
                        n_found  = FW'(r_pend_idx);
                    end
                end else if (w_scan_end) begin
                    n_strobe = 1'b1;
                    n_status = ulst_pkg::ST_NOT_FOUND;
                end
            end
            ulst_pkg::S_MOVE: begin
                // fetch the tail entry
                w_raddr = w_last_idx[IDX_W-1:0];
            end
            ulst_pkg::S_COMMIT: begin
                w_we     = 1'b1;
                w_waddr  = r_pos;
                w_wdata  = w_rdata;
                n_count  = w_last_idx;
                n_strobe = 1'b1;
                n_found  = FW'(r_pos);
            end
            ulst_pkg::S_DUMP: begin
                n_pend = (r_idx < w_dump_n);
                if (r_pend) begin
                    n_strobe = 1'b1;
                    n_entry  = w_rdata;
                    n_last   = w_dump_end;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ulst_pkg::S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx             <= n_idx;
        r_pend_idx        <= n_pend_idx;
        r_pos             <= n_pos;
        r_value           <= n_value;
        r_value_is_remove <= n_value_is_remove;
        r_status          <= n_status;
        r_found           <= n_found;
        r_entry           <= n_entry;
        r_last            <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_entry_value = r_entry;
    assign o_last        = r_last;

endmodule : unordered_array_list_core
`default_nettype wire

// ===== dv/tb_unordered_array_list_core.sv =====
// ----------------------------------------------------------------------------
// tb_unordered_array_list_core
// Self-checking bench for the unordered list core: drives insert, search,
// remove and dump requests over the start/busy handshake, predicts every
// result from a private copy of the list and compares each strobed result.
// ----------------------------------------------------------------------------
module tb_unordered_array_list_core;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_GAP = 12;
    localparam int DATA_W = ulst_pkg::DATA_W;
    localparam int FIDX_W = ulst_pkg::FIDX_W;
    localparam int CAPACITY_DEF = ulst_pkg::CAPACITY_DEF;
    localparam int MAX_RESULTS = ulst_pkg::MAX_RESULTS;

    typedef struct packed {
        ulst_pkg::t_status  status;
        logic [FIDX_W-1:0]  index;
        logic [DATA_W-1:0]  value;
        logic               last;
    } t_list_result;

    // Shadow of the list contents plus the queue of results still owed.
    class list_scoreboard;
        logic [DATA_W-1:0] slots[CAPACITY_DEF];
        int                fill;
        t_list_result      owed_q[$];
        int                mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function void owe(ulst_pkg::t_status st, int idx, logic [DATA_W-1:0] val,
                          logic lst);
            t_list_result r;
            r.status = st;
            r.index  = idx[FIDX_W-1:0];
            r.value  = val;
            r.last   = lst;
            owed_q.push_back(r);
        endfunction

        function void note_request(ulst_pkg::t_req req, logic [DATA_W-1:0] val);
            int pos;
            int n;
            pos = -1;
            case (req)
                ulst_pkg::REQ_INSERT: begin
                    if (fill >= CAPACITY_DEF) begin
                        owe(ulst_pkg::ST_FULL, 0, '0, 1'b1);
                    end else begin
                        slots[fill] = val;
                        fill++;
                        owe(ulst_pkg::ST_OK, 0, '0, 1'b1);
                    end
                end
                ulst_pkg::REQ_SEARCH, ulst_pkg::REQ_REMOVE: begin
                    if (fill == 0) begin
                        owe(ulst_pkg::ST_EMPTY, 0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            if (pos < 0 && slots[i] == val) pos = i;
                        end
                        if (pos < 0) begin
                            owe(ulst_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
                        end else begin
                            // swap the tail entry into the hole
                            if (req == ulst_pkg::REQ_REMOVE) begin
                                slots[pos] = slots[fill-1];
                                fill--;
                            end
                            owe(ulst_pkg::ST_OK, pos, '0, 1'b1);
                        end
                    end
                end
                default: begin
                    if (fill == 0) begin
                        owe(ulst_pkg::ST_EMPTY, 0, '0, 1'b1);
                    end else begin
                        n = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
                        for (int i = 0; i < n; i++)
                            owe(ulst_pkg::ST_OK, 0, slots[i], i == n - 1);
                    end
                end
            endcase
        endfunction

        function void check_result(t_list_result got);
            t_list_result exp;
            if (owed_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: status=%0d index=%0d value=%h last=%0b",
                             got.status, got.index, got.value, got.last);
                mismatches++;
            end else begin
                exp = owed_q.pop_front();
                if (got.status !== exp.status || got.index !== exp.index ||
                    got.value !== exp.value || got.last !== exp.last) begin
                    if (mismatches < 10)
                        $display({"result mismatch: exp status=%0d index=%0d value=%h last=%0b",
                                  " / got status=%0d index=%0d value=%h last=%0b"},
                                 exp.status, exp.index, exp.value, exp.last,
                                 got.status, got.index, got.value, got.last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_req_type;
    logic [DATA_W-1:0]    i_item_value;
    logic                 o_strobe;
    logic [1:0]           o_status;
    logic [FIDX_W-1:0]    o_found_index;
    logic [DATA_W-1:0]    o_entry_value;
    logic                 o_last;

    list_scoreboard sb;
    int             sender_idle_pct;
    int             cycles;

    unordered_array_list_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_item_value  (i_item_value),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_value (o_entry_value),
        .o_last        (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Note the accepted item before checking, so a same-edge result finds it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_request(ulst_pkg::t_req'(i_req_type), i_item_value);
            if (o_strobe)
                sb.check_result({ulst_pkg::t_status'(o_status), o_found_index,
                                 o_entry_value, o_last});
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** unordered_array_list_core: FAILED **");
            $finish;
        end
    end

    // Present one item and hold it until the core takes it; start stays high.
    task automatic send(ulst_pkg::t_req req, logic [DATA_W-1:0] val);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_item_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // Favor values already in the list so searches and removes hit.
    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(3);
        if (sel < 2 && sb.fill > 0) return sb.slots[$urandom_range(sb.fill - 1)];
        if (sel == 2) return DATA_W'($urandom_range(7));
        return $urandom;
    endfunction

    task automatic run_random(int items, int ins_pct, int srch_pct, int rem_pct);
        int             r;
        ulst_pkg::t_req req;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            if (r < ins_pct) req = ulst_pkg::REQ_INSERT;
            else if (r < ins_pct + srch_pct) req = ulst_pkg::REQ_SEARCH;
            else if (r < ins_pct + srch_pct + rem_pct) req = ulst_pkg::REQ_REMOVE;
            else req = ulst_pkg::REQ_DUMP;
            send(req, pick_value());
        end
    endtask

    initial begin
        sb = new();
        sender_idle_pct = 16;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= ulst_pkg::REQ_INSERT;
        i_item_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // requests against an empty list
        send(ulst_pkg::REQ_DUMP,   '0);
        send(ulst_pkg::REQ_SEARCH, '0);
        send(ulst_pkg::REQ_REMOVE, '0);
        send(ulst_pkg::REQ_INSERT, 32'h8000_0000);
        send(ulst_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        send(ulst_pkg::REQ_INSERT, 32'h0000_0000);
        send(ulst_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send(ulst_pkg::REQ_SEARCH, 32'h7FFF_FFFF);
        send(ulst_pkg::REQ_SEARCH, 32'h1234_5678);
        // head removal swaps the tail in; then remove the tail itself
        send(ulst_pkg::REQ_REMOVE, 32'h8000_0000);
        send(ulst_pkg::REQ_REMOVE, 32'h0000_0000);
        send(ulst_pkg::REQ_DUMP,   '0);
        // fill with duplicates up to capacity, then overflow
        for (int i = 0; i < CAPACITY_DEF - 2; i++)
            send(ulst_pkg::REQ_INSERT, DATA_W'(i % 3));
        send(ulst_pkg::REQ_INSERT, 32'h0000_0005);
        send(ulst_pkg::REQ_DUMP,   '0);

        run_random(24, 50, 15, 20);
        sender_idle_pct = 62;
        run_random(24, 30, 20, 35);
        sender_idle_pct = 0;
        run_random(24, 35, 25, 25);
        start <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("** unordered_array_list_core: PASSED **");
        end else begin
            $display("** unordered_array_list_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== unordered_array_list_core.f =====
sv/ulst_pkg.sv
sv/ulst_ram.sv
sv/unordered_array_list_core.sv
dv/tb_unordered_array_list_core.sv
